// ===== src/assert_macros.svh =====
// Assertion macros used by station_table_with_aging.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("assert");
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("assert");
`else
`define ASSERT_IMP(lbl, clk, rst_n, a, c)
`define ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ===== src/stwa_pkg.sv =====
// ----------------------------------------------------------------------------
// stwa_pkg
// Shared constants and types of the station table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package stwa_pkg;
  localparam int SLOTS_DEF = 8;
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_SWEEP  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;
  localparam logic [2:0] ST_EXIST = 3'd0;
  localparam logic [2:0] ST_FREE  = 3'd1;
  localparam logic [2:0] ST_EVICT = 3'd2;
  localparam logic [2:0] ST_BADCO = 3'd3;
  localparam logic [2:0] ST_BADSP = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_ALPHA   = 2'd1;
  localparam logic [1:0] CFG_SPEED   = 2'd2;
  localparam logic signed [31:0] LAT_MAX = 32'sd900000000;
  localparam logic signed [31:0] LON_MAX = 32'sd1800000000;

  typedef struct packed {
    logic        valid;
    logic        sig_f;
    logic        risk_f;
    logic        pos_f;
    logic [47:0] addr;
    logic [31:0] stamp;
    logic [7:0]  raw;
    logic [15:0] ema;
    logic [1:0]  risk;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [15:0] speed;
  } entry_t;
endpackage

// ===== src/stwa_ema.sv =====
// ----------------------------------------------------------------------------
// stwa_ema
// Registered Q8.8 moving average: two products, one sum, saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stwa_ema (
  input  logic               clk,
  input  logic [8:0]         alpha,
  input  logic signed [7:0]  raw,
  input  logic signed [15:0] prev,
  output logic signed [15:0] ema_r
);
  logic [8:0] a;
  logic signed [31:0] p1_r, p2_r, s;
  logic signed [23:0] q;
  logic signed [15:0] ema_nxt;
  assign a = (alpha > 9'd256) ? 9'd256 : alpha;
  always_ff @(posedge clk) begin
    p1_r <= $signed({23'd0, a}) * 32'(raw) * 32'sd256;
    p2_r <= $signed(32'(10'd256 - {1'b0, a})) * 32'(prev);
    ema_r <= ema_nxt;
  end
  always_comb begin
    s = p1_r + p2_r + 32'sd128;
    q = 24'(s >>> 8);
    if (q > 24'sd32767) ema_nxt = 16'sh7fff;
    else if (q < -24'sd32768) ema_nxt = 16'sh8000;
    else ema_nxt = q[15:0];
  end
endmodule

// ===== src/station_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// station_table_with_aging
// Station table keyed by 48-bit address, with signal smoothing and aging.
// ----------------------------------------------------------------------------
// Usage:
//  in_*   : one item per transaction (opcode update / sweep / read).
//  out_*  : one result per item.
//  cfg_*  : register writes (0 timeout_ms, 1 smoothing_alpha, 2 speed_limit),
//           always ready; write only while idle.
// Timing: an item is first checked, then one slot is visited per cycle
// by a single compare unit (address match, free slot, oldest stamp, expiry).
// An accepted update registers its result after check, scan, smoothing and
// commit; a sweep registers its result with the visit of the last slot.
// Rejected updates, reads and unused opcodes register theirs in the check
// state. in_tready is low during the work and while a result waits, so
// a new item is accepted only after the last is done and its result taken.
// The result sits in an output register until taken; a stalled receiver
// holds the block with the result pending, and the next item is accepted
// once the result is gone. Reset clears all slots (valid bits and data in
// flip-flops) and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module station_table_with_aging #(
  parameter int SLOTS = stwa_pkg::SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[1:0] station_addr[49:2] has_signal[50] signal_dbm[58:51]
  // remote_flag[59] risk_level[61:60] latitude[93:62] longitude[125:94]
  // speed[141:126] now_ms[173:142] slot_index[176:174]
  input  logic [183:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0] slot[5:3] active_count[9:6] entry_flags[13:10]
  // entry_addr[61:14] entry_signal_raw[69:62] entry_signal_smoothed[85:70]
  // entry_risk[87:86] entry_latitude[119:88] entry_longitude[151:120]
  // entry_speed[167:152] entry_last_seen[199:168]
  output logic [199:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_EMA = 5'b00100,
    S_COMMIT = 5'b01000, S_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  stwa_pkg::entry_t tab_r [SLOTS];
  logic [31:0] timeout_r;
  logic [8:0]  alpha_r;
  logic [15:0] speedlim_r;
  logic [183:0] it_r;
  logic [IW:0]  cnt_r;
  logic [IW-1:0] idx;
  logic          hit_r, free_r;
  logic [IW-1:0] hit_i_r, free_i_r, old_i_r;
  logic [31:0]   old_s_r;
  logic [1:0]    ewait_r;
  logic [199:0]  out_r;
  logic          outv_r;
  logic [IW-1:0] tgt;
  logic [2:0]    stat;
  logic signed [15:0] ema_q;
  logic [CW-1:0] act;

  logic [1:0]  op;
  logic [47:0] addr;
  logic        hsig, remote;
  logic signed [7:0] sig;
  logic [1:0]  risk;
  logic signed [31:0] lat, lon;
  logic signed [15:0] spd;
  logic [31:0] now;
  logic [2:0]  sidx;
  stwa_pkg::entry_t cur, e;

  assign op = it_r[1:0];
  assign addr = it_r[49:2];
  assign hsig = it_r[50];
  assign sig = it_r[58:51];
  assign remote = it_r[59];
  assign risk = it_r[61:60];
  assign lat = it_r[93:62];
  assign lon = it_r[125:94];
  assign spd = it_r[141:126];
  assign now = it_r[173:142];
  assign sidx = it_r[176:174];

  assign in_tready = (state_r == S_IDLE) && !outv_r;
  assign out_tvalid = outv_r;
  assign out_tdata = out_r;
  assign cfg_ready = 1'b1;
  assign idx = cnt_r[IW-1:0];
  assign cur = tab_r[idx];

  always_comb begin
    act = '0;
    for (int i = 0; i < SLOTS; i++) act = act + CW'(tab_r[i].valid);
  end

  assign tgt = hit_r ? hit_i_r : (free_r ? free_i_r : old_i_r);
  assign stat = hit_r ? stwa_pkg::ST_EXIST : (free_r ? stwa_pkg::ST_FREE : stwa_pkg::ST_EVICT);

  stwa_ema u_ema (.clk(clk), .alpha(alpha_r), .raw(sig), .prev(tab_r[tgt].ema), .ema_r(ema_q));

  function automatic logic [199:0] pack(logic [2:0] st, logic [2:0] sl, logic [3:0] ac,
                                        stwa_pkg::entry_t x, logic use_e);
    logic [199:0] r;
    r = '0;
    r[2:0] = st; r[5:3] = sl; r[9:6] = ac;
    if (use_e) begin
      r[13:10] = {x.pos_f, x.risk_f, x.sig_f, x.valid};
      r[61:14] = x.addr; r[69:62] = x.raw; r[85:70] = x.ema; r[87:86] = x.risk;
      r[119:88] = x.lat; r[151:120] = x.lon; r[167:152] = x.speed;
      r[199:168] = x.stamp;
    end
    return r;
  endfunction

  // checks
  logic bad_co, bad_sp;
  assign bad_co = !remote && (lat < -stwa_pkg::LAT_MAX || lat > stwa_pkg::LAT_MAX ||
                  lon < -stwa_pkg::LON_MAX || lon > stwa_pkg::LON_MAX);
  assign bad_sp = !remote && (spd < 0 || {1'b0, spd[14:0]} > speedlim_r);

  always_comb begin
    e = tab_r[tgt];
    if (!hit_r) e = '0;
    e.valid = 1'b1; e.addr = addr; e.stamp = now;
    if (hsig) begin
      e.ema = e.sig_f ? ema_q : 16'(sig) <<< 8;
      e.sig_f = 1'b1; e.raw = sig;
    end
    if (remote) begin
      e.risk_f = 1'b1; e.risk = risk; e.pos_f = 1'b0;
    end else begin
      e.pos_f = 1'b1; e.lat = lat; e.lon = lon; e.speed = spd;
      e.risk_f = 1'b0; e.risk = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid && in_tready) state_nxt = S_OUT;
      S_OUT: begin
        if (op == stwa_pkg::OP_UPDATE && !bad_co && !bad_sp) state_nxt = S_SCAN;
        else if (op == stwa_pkg::OP_SWEEP) state_nxt = S_SCAN;
        else state_nxt = S_IDLE;
      end
      S_SCAN:   if (cnt_r == (IW+1)'(SLOTS - 1))
                  state_nxt = (op == stwa_pkg::OP_SWEEP) ? S_IDLE : S_EMA;
      S_EMA:    if (ewait_r == 2'd1) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outv_r <= 1'b0;
      timeout_r <= 32'd5000; alpha_r <= 9'd77; speedlim_r <= 16'd8000;
      for (int i = 0; i < SLOTS; i++) tab_r[i] <= '0;
      cnt_r <= '0; ewait_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (outv_r && out_tready) outv_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          stwa_pkg::CFG_TIMEOUT: timeout_r <= cfg_data;
          stwa_pkg::CFG_ALPHA:   alpha_r <= cfg_data[8:0];
          stwa_pkg::CFG_SPEED:   speedlim_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) it_r <= in_tdata;
        S_OUT: begin
          cnt_r <= '0; ewait_r <= '0;
          hit_r <= 1'b0; free_r <= 1'b0; old_s_r <= tab_r[0].stamp;
          hit_i_r <= '0; free_i_r <= '0; old_i_r <= '0;
          if (op == stwa_pkg::OP_READ) begin
            outv_r <= 1'b1;
            out_r <= pack(stwa_pkg::ST_DONE, sidx, 4'(act), tab_r[sidx[IW-1:0]],
                          {29'd0, sidx} < SLOTS);
          end else if (op == stwa_pkg::OP_UPDATE && bad_co) begin
            outv_r <= 1'b1; out_r <= pack(stwa_pkg::ST_BADCO, 3'd0, 4'(act), cur, 1'b0);
          end else if (op == stwa_pkg::OP_UPDATE && bad_sp) begin
            outv_r <= 1'b1; out_r <= pack(stwa_pkg::ST_BADSP, 3'd0, 4'(act), cur, 1'b0);
          end else if (op != stwa_pkg::OP_UPDATE && op != stwa_pkg::OP_SWEEP) begin
            outv_r <= 1'b1; out_r <= pack(stwa_pkg::ST_DONE, 3'd0, 4'(act), cur, 1'b0);
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (op == stwa_pkg::OP_SWEEP) begin
            if (cur.valid && (now - cur.stamp) > timeout_r) tab_r[idx].valid <= 1'b0;
          end else begin
            if (!hit_r && cur.valid && cur.addr == addr) begin
              hit_r <= 1'b1; hit_i_r <= idx;
            end
            if (!free_r && !cur.valid) begin
              free_r <= 1'b1; free_i_r <= idx;
            end
            if (cur.stamp < old_s_r) begin
              old_s_r <= cur.stamp; old_i_r <= idx;
            end
          end
          if (state_nxt == S_IDLE) outv_r <= 1'b1;
          if (op == stwa_pkg::OP_SWEEP && state_nxt == S_IDLE)
            out_r <= pack(stwa_pkg::ST_DONE, 3'd0, 4'(act -
                     CW'(cur.valid && (now - cur.stamp) > timeout_r)), cur, 1'b0);
        end
        S_EMA: ewait_r <= ewait_r + 2'd1;
        S_COMMIT: begin
          tab_r[tgt] <= e;
          outv_r <= 1'b1;
          out_r <= pack(stat, 3'(tgt), 4'(act + CW'(!hit_r && free_r)), e, 1'b1);
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMP(a_busy, clk, rst_n, state_r != S_IDLE, !in_tready)
  `ASSERT_NXT(a_commit, clk, rst_n, state_r == S_COMMIT, out_tvalid && state_r == S_IDLE)
  `ASSERT_IMP(a_cnt, clk, rst_n, state_r == S_SCAN, cnt_r < (IW+1)'(SLOTS))
  `ASSERT_IMP(a_outhold, clk, rst_n, out_tvalid && !out_tready, !in_tready)
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives station table updates, sweeps and reads through the stream ports,
// predicts each result from a software copy of the table and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  localparam int NSLOT = stwa_pkg::SLOTS_DEF;
  localparam int N_RANDOM = 750;

  // one station slot of the predictor
  typedef struct {
    bit          valid;
    bit          sig_f;
    bit          risk_f;
    bit          pos_f;
    bit [47:0]   addr;
    bit [31:0]   stamp;
    bit [7:0]    raw;
    bit [15:0]   ema;
    bit [1:0]    risk;
    bit [31:0]   lat;
    bit [31:0]   lon;
    bit [15:0]   speed;
  } slot_t;

  typedef struct packed {
    bit [2:0]  slot_index;
    bit [31:0] now_ms;
    bit [15:0] speed;
    bit [31:0] lon;
    bit [31:0] lat;
    bit [1:0]  risk;
    bit        remote;
    bit [7:0]  dbm;
    bit        has_sig;
    bit [47:0] addr;
    bit [1:0]  op;
  } station_req_t;

  typedef struct packed {
    bit [31:0] last_seen;
    bit [15:0] speed;
    bit [31:0] lon;
    bit [31:0] lat;
    bit [1:0]  risk;
    bit [15:0] ema;
    bit [7:0]  raw;
    bit [47:0] addr;
    bit [3:0]  flags;
    bit [3:0]  active;
    bit [2:0]  slot;
    bit [2:0]  status;
  } station_resp_t;

  // ------------------------------------------------------------------------
  // Scoreboard: keeps the table model and the queue of pending responses.
  // ------------------------------------------------------------------------
  class station_scoreboard;
    slot_t         tbl[NSLOT];
    bit [31:0]     timeout_ms;
    bit [8:0]      alpha;
    bit [15:0]     speed_limit;
    station_resp_t pending[$];
    int            errors;
    int            checked;

    function void reset_table();
      foreach (tbl[i]) tbl[i] = '{default: 0};
      timeout_ms = 5000;
      alpha = 77;
      speed_limit = 8000;
    endfunction

    function void write_reg(bit [1:0] idx, bit [31:0] data);
      if (idx == stwa_pkg::CFG_TIMEOUT) timeout_ms = data;
      else if (idx == stwa_pkg::CFG_ALPHA) alpha = data[8:0];
      else if (idx == stwa_pkg::CFG_SPEED) speed_limit = data[15:0];
    endfunction

    function bit [15:0] smooth(bit [15:0] prev, bit [7:0] raw);
      longint a, s, r;
      a = (alpha > 256) ? 256 : alpha;
      s = a * longint'($signed(raw)) * 256 + (256 - a) * longint'($signed(prev)) + 128;
      r = s >>> 8;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function station_resp_t respond(bit [2:0] st, bit [2:0] sl, int idx);
      station_resp_t r;
      r = '0;
      r.status = st;
      r.slot = sl;
      foreach (tbl[i]) r.active += tbl[i].valid;
      if (idx >= 0 && idx < NSLOT) begin
        r.flags = {tbl[idx].pos_f, tbl[idx].risk_f, tbl[idx].sig_f, tbl[idx].valid};
        r.addr = tbl[idx].addr;
        r.raw = tbl[idx].raw;
        r.ema = tbl[idx].ema;
        r.risk = tbl[idx].risk;
        r.lat = tbl[idx].lat;
        r.lon = tbl[idx].lon;
        r.speed = tbl[idx].speed;
        r.last_seen = tbl[idx].stamp;
      end
      return r;
    endfunction

    // note an accepted request and queue its predicted response
    function void note_request(station_req_t q);
      int idx;
      bit [2:0] st;
      bit [31:0] best;
      idx = -1;
      if (q.op == stwa_pkg::OP_SWEEP) begin
        foreach (tbl[i])
          if (tbl[i].valid && (q.now_ms - tbl[i].stamp) > timeout_ms) tbl[i].valid = 0;
        pending.push_back(respond(stwa_pkg::ST_DONE, 0, -1));
        return;
      end
      if (q.op == stwa_pkg::OP_READ) begin
        pending.push_back(respond(stwa_pkg::ST_DONE, q.slot_index, q.slot_index));
        return;
      end
      if (q.op != stwa_pkg::OP_UPDATE) begin
        pending.push_back(respond(stwa_pkg::ST_DONE, 0, -1));
        return;
      end
      if (!q.remote) begin
        if ($signed(q.lat) < -stwa_pkg::LAT_MAX || $signed(q.lat) > stwa_pkg::LAT_MAX ||
            $signed(q.lon) < -stwa_pkg::LON_MAX || $signed(q.lon) > stwa_pkg::LON_MAX) begin
          pending.push_back(respond(stwa_pkg::ST_BADCO, 0, -1));
          return;
        end
        if (q.speed[15] || q.speed > speed_limit) begin
          pending.push_back(respond(stwa_pkg::ST_BADSP, 0, -1));
          return;
        end
      end
      for (int i = 0; i < NSLOT && idx < 0; i++)
        if (tbl[i].valid && tbl[i].addr == q.addr) idx = i;
      st = stwa_pkg::ST_EXIST;
      if (idx < 0) begin
        for (int i = 0; i < NSLOT && idx < 0; i++)
          if (!tbl[i].valid) idx = i;
        st = stwa_pkg::ST_FREE;
        if (idx < 0) begin
          idx = 0;
          best = tbl[0].stamp;
          for (int i = 1; i < NSLOT; i++)
            if (tbl[i].stamp < best) begin
              best = tbl[i].stamp;
              idx = i;
            end
          st = stwa_pkg::ST_EVICT;
        end
        tbl[idx] = '{default: 0};
      end
      tbl[idx].valid = 1;
      tbl[idx].addr = q.addr;
      tbl[idx].stamp = q.now_ms;
      if (q.has_sig) begin
        tbl[idx].ema = tbl[idx].sig_f ? smooth(tbl[idx].ema, q.dbm)
                                      : {q.dbm, 8'h00};
        tbl[idx].sig_f = 1;
        tbl[idx].raw = q.dbm;
      end
      if (q.remote) begin
        tbl[idx].risk_f = 1;
        tbl[idx].risk = q.risk;
        tbl[idx].pos_f = 0;
      end else begin
        tbl[idx].pos_f = 1;
        tbl[idx].lat = q.lat;
        tbl[idx].lon = q.lon;
        tbl[idx].speed = q.speed;
        tbl[idx].risk_f = 0;
        tbl[idx].risk = 0;
      end
      pending.push_back(respond(st, idx[2:0], idx));
    endfunction

    function void check_response(station_resp_t got);
      station_resp_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected response %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: response %0d mismatch", checked);
          $display("  exp st=%0d sl=%0d n=%0d fl=%h ad=%h raw=%h ema=%h rk=%0d",
                   exp_r.status, exp_r.slot, exp_r.active, exp_r.flags, exp_r.addr,
                   exp_r.raw, exp_r.ema, exp_r.risk);
          $display("      lat=%h lon=%h sp=%h ts=%h",
                   exp_r.lat, exp_r.lon, exp_r.speed, exp_r.last_seen);
          $display("  got st=%0d sl=%0d n=%0d fl=%h ad=%h raw=%h ema=%h rk=%0d",
                   got.status, got.slot, got.active, got.flags, got.addr,
                   got.raw, got.ema, got.risk);
          $display("      lat=%h lon=%h sp=%h ts=%h",
                   got.lat, got.lon, got.speed, got.last_seen);
        end
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [183:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [199:0] out_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = stwa_pkg::CFG_TIMEOUT;
  logic [31:0]  cfg_data = '0;

  station_scoreboard sb;
  bit stall_on = 1;   // receiver stall pattern enabled
  int n_updates, n_sweeps, n_reads;

  always #5 clk = ~clk;

  station_table_with_aging u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Receiver: stall pattern of its own, with stall-free stretches.
  int rx_phase = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata[199:0]);
    rx_phase <= rx_phase + 1;
    if (!stall_on || (rx_phase % 512) >= 400) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 99) < 65);
  end

  // Write one register; only called while the table is idle.
  // cfg_valid stays high; the caller drops it after the last write.
  task automatic write_reg(bit [1:0] idx, bit [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Send one transaction; tvalid stays high, the caller drops it for a gap.
  task automatic send_req(station_req_t q);
    in_tvalid <= 1;
    in_tdata <= 184'(q);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(q);
    case (q.op)
      stwa_pkg::OP_UPDATE: n_updates++;
      stwa_pkg::OP_SWEEP:  n_sweeps++;
      default:             n_reads++;
    endcase
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // small address pool so matches, evictions and re-learns happen often
  function automatic bit [47:0] pick_addr();
    int k;
    k = $urandom_range(0, 11);
    if (k == 11) return 48'({$urandom, $urandom});
    return 48'hA5_0000_0000 ^ (48'h1 << (k * 4)) ^ (k == 10 ? 48'hFFFF_FFFF_FFFF : 48'h0);
  endfunction

  bit [31:0] clock_ms = 0;

  function automatic station_req_t rand_req();
    station_req_t q;
    int pick;
    q = '0;
    q.now_ms = clock_ms;
    clock_ms += $urandom_range(0, 1500);
    if ($urandom_range(0, 19) == 0) q.now_ms = $urandom;
    q.addr = pick_addr();
    q.has_sig = $urandom_range(0, 1);
    q.dbm = $urandom;
    q.remote = $urandom_range(0, 1);
    q.risk = $urandom;
    q.lat = $urandom_range(0, 1800000000) - 900000000;
    q.lon = $urandom_range(0, 32'd3600000000) - 1800000000;
    q.speed = $urandom_range(0, 9000);
    q.slot_index = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 8) q.lat = $urandom;
    else if (pick < 14) q.lon = $urandom;
    else if (pick < 20) q.speed = $urandom;
    pick = $urandom_range(0, 99);
    q.op = pick < 70 ? stwa_pkg::OP_UPDATE :
           pick < 82 ? stwa_pkg::OP_SWEEP :
           pick < 98 ? stwa_pkg::OP_READ : stwa_pkg::OP_NONE;
    return q;
  endfunction

  // directed items: boundaries of fields and each validation case
  task automatic directed();
    station_req_t q;
    for (int i = 0; i < 22; i++) begin
      q = '0;
      q.op = stwa_pkg::OP_UPDATE;
      q.addr = 48'h1000 + i;
      q.now_ms = i * 10;
      q.has_sig = 1;
      q.dbm = (i % 2) ? 8'h80 : 8'h7F;
      case (i)
        0: q.lat = 900000000;
        1: q.lat = -900000000;
        2: q.lat = 900000001;
        3: q.lat = -900000001;
        4: q.lon = 1800000000;
        5: q.lon = -1800000000;
        6: q.lon = 1800000001;
        7: q.lon = 32'h8000_0000;
        8: q.speed = 16'hFFFF;
        9: q.speed = 8000;
        10: q.speed = 8001;
        11: begin q.remote = 1; q.risk = 3; q.lat = 32'h7FFF_FFFF; q.speed = 16'h8000; end
        12: begin q.addr = 48'h1000; q.dbm = 8'h80; end
        13: begin q.addr = 48'hFFFF_FFFF_FFFF; q.remote = 1; end
        14: begin q.addr = 0; q.has_sig = 0; end
        15, 16, 17: q.now_ms = 32'hFFFF_FFFF - i;
        18: begin q.op = stwa_pkg::OP_SWEEP; q.now_ms = 32'hFFFF_FFFF; end
        19: begin q.op = stwa_pkg::OP_READ; q.slot_index = 7; end
        20: begin q.op = stwa_pkg::OP_READ; q.slot_index = 0; end
        21: q.op = stwa_pkg::OP_NONE;
        default: ;
      endcase
      send_req(q);
    end
    in_tvalid <= 0;
  endtask

  initial begin
    int burst;
    int gap;
    bit held;
    station_req_t q;
    sb = new();
    sb.reset_table();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed();
    drain();
    // register settings per phase, extremes among them
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(stwa_pkg::CFG_ALPHA, 0); write_reg(stwa_pkg::CFG_SPEED, 65535); end
        1: begin write_reg(stwa_pkg::CFG_ALPHA, 256); write_reg(stwa_pkg::CFG_TIMEOUT, 0); end
        2: begin write_reg(stwa_pkg::CFG_ALPHA, 511); write_reg(stwa_pkg::CFG_SPEED, 0);
                 write_reg(stwa_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF); end
        3: begin write_reg(stwa_pkg::CFG_ALPHA, 77); write_reg(stwa_pkg::CFG_SPEED, 8000);
                 write_reg(stwa_pkg::CFG_TIMEOUT, 3000); end
        default: begin write_reg(stwa_pkg::CFG_ALPHA, $urandom_range(1, 255));
                       write_reg(stwa_pkg::CFG_TIMEOUT, $urandom_range(500, 6000)); end
      endcase
      cfg_valid <= 0;
      stall_on = (ph != 3);
      held = 0;
      for (int n = 0; n < N_RANDOM / 5; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < N_RANDOM / 5; b++, n++) begin
          q = rand_req();
          send_req(q);
        end
        gap = $urandom_range(0, 6);
        if (n >= N_RANDOM / 5 || (!held && n >= 60)) begin
          // full hold-off until the table is quiet
          held = 1;
          in_tvalid <= 0;
          drain();
        end else if (gap != 0) begin
          in_tvalid <= 0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    $display("Covered %0d updates, %0d sweeps, %0d reads/other over 5 register settings.",
             n_updates, n_sweeps, n_reads);
    $display("Compared %0d responses, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("Some tests failed");
    $finish;
  end
endmodule
